/* rtl/core/fbfrh_pkg.sv */
// shared types and constants of the frame store core
// no dependencies

package fbfrh_pkg;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_HASH  = 2'd2,
    ACT_MARK  = 2'd3
  } action_e;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef struct packed {
    logic clr;
    logic pix_valid;
  } hash_ctrl_t;

endpackage

/* rtl/core/fbfrh_hash.sv */
// fnv-1a 32 checksum unit, one byte per cycle, high byte of each pixel first
// depends on fbfrh_pkg

module fbfrh_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbfrh_pkg::hash_ctrl_t ctrl_i,
  input  logic [15:0]           pix_i,
  output logic [31:0]           hash_o
);

  logic [31:0] hash_q;
  logic [7:0]  lo_q;
  logic        lo_pend_q;
  logic [7:0]  byte_sel;
  logic [31:0] mixed;
  logic [31:0] prod;

  assign byte_sel = lo_pend_q ? lo_q : pix_i[15:8];
  assign mixed    = hash_q ^ {24'd0, byte_sel};
  assign prod     = mixed * fbfrh_pkg::HASH_PRIME;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_pend_q <= 1'b0;
    end else begin
      lo_pend_q <= ctrl_i.pix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      hash_q <= fbfrh_pkg::HASH_BASIS;
    end else if (ctrl_i.pix_valid || lo_pend_q) begin
      hash_q <= prod;
    end
    if (ctrl_i.pix_valid) begin
      lo_q <= pix_i[7:0];
    end
  end

  assign hash_o = hash_q;

  a_no_byte_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_pend_q |-> !ctrl_i.pix_valid) else $error("pixel arrived during low byte");

  a_lo_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pix_valid |=> lo_pend_q) else $error("low byte not scheduled");

  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |-> !ctrl_i.pix_valid && !lo_pend_q) else $error("clear during hashing");

endmodule

/* rtl/core/framebuffer_fill_rotate_hash_core.sv */
// rgb565 frame store with clipped, rotated rectangle fill and fnv-1a checksum
// depends on fbfrh_pkg and fbfrh_hash
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata {color,h,w,y,x}, tuser action
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata {pad,dirty,frame_hash}
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i rotation
//
// pixel write and fill: clip, map and base states, then the fill state writes the stored pixels
// checksum: one memory read and two hash bytes per stored pixel, then the tail state
// mark presented and clipped-away writes: the clip state leads straight to the result state
// the core is ready for the next word in the cycle after a result is loaded
// reset clears control and the dirty flag; the store holds garbage until written
// one item at a time; a result waits in the output register while the next item runs

module framebuffer_fill_rotate_hash_core #(
  parameter int PANEL_WIDTH  = 172,
  parameter int PANEL_HEIGHT = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // x_pos, y_pos, rect_width, rect_height, color
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // frame_hash, dirty, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LMAX  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int CW    = $clog2(LMAX + 1);
  localparam logic signed [16:0] PW_S = 17'(PANEL_WIDTH);
  localparam logic signed [16:0] PH_S = 17'(PANEL_HEIGHT);
  localparam logic [CW-1:0]      PW_C = CW'(PANEL_WIDTH);
  localparam logic [CW-1:0]      PH_C = CW'(PANEL_HEIGHT);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]      ROW_STEP  = AW'(PANEL_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_MAP,
    ST_BASE,
    ST_FILL,
    ST_HASH,
    ST_TAIL,
    ST_RESULT
  } state_e;

  state_e              state_q;
  fbfrh_pkg::action_e  act_q;
  logic [1:0]          rot_q;
  logic                dirty_q;
  logic                phase_q;
  logic                last_q;
  logic [AW-1:0]       rd_addr_q;
  logic                m_valid_q;
  logic [39:0]         m_data_q;

  logic signed [15:0]  x_q, y_q, w_q, h_q;
  logic [15:0]         color_q;
  logic [CW-1:0]       x0_q, x1_q, y0_q, y1_q;
  logic                empty_q;
  logic [CW-1:0]       px_lo_q, px_hi_q, py_lo_q, py_hi_q;
  logic [CW-1:0]       px_q, py_q;
  logic [AW-1:0]       row_base_q;

  logic [15:0]         mem [DEPTH];
  logic [15:0]         rd_data_q;

  // clip stage
  logic signed [15:0]  wv, hv;
  logic signed [16:0]  x_s, y_s, x_end, y_end, lw_s, lh_s, x0_s, y0_s, x1_s, y1_s;
  logic                empty_c;
  // map stage
  logic [CW-1:0]       px_lo_c, px_hi_c, py_lo_c, py_hi_c;
  logic                out_free, mem_we, rd_en, row_end, rect_end;
  logic [AW-1:0]       wr_addr;
  fbfrh_pkg::hash_ctrl_t hash_ctrl;
  logic [31:0]         hash_val;

  always_comb begin
    wv    = (act_q == fbfrh_pkg::ACT_PIXEL) ? 16'sd1 : w_q;
    hv    = (act_q == fbfrh_pkg::ACT_PIXEL) ? 16'sd1 : h_q;
    x_s   = 17'(x_q);
    y_s   = 17'(y_q);
    x_end = x_s + 17'(wv);
    y_end = y_s + 17'(hv);
    lw_s  = rot_q[0] ? PH_S : PW_S;
    lh_s  = rot_q[0] ? PW_S : PH_S;
    x0_s  = x_q[15] ? 17'sd0 : x_s;
    y0_s  = y_q[15] ? 17'sd0 : y_s;
    x1_s  = (x_end > lw_s) ? lw_s : x_end;
    y1_s  = (y_end > lh_s) ? lh_s : y_end;
    empty_c = (wv < 16'sd1) || (hv < 16'sd1) || (x0_s >= x1_s) || (y0_s >= y1_s);
  end

  always_comb begin
    case (rot_q)
      fbfrh_pkg::ROT_90: begin
        px_lo_c = PW_C - y1_q;  px_hi_c = PW_C - y0_q;
        py_lo_c = x0_q;         py_hi_c = x1_q;
      end
      fbfrh_pkg::ROT_180: begin
        px_lo_c = PW_C - x1_q;  px_hi_c = PW_C - x0_q;
        py_lo_c = PH_C - y1_q;  py_hi_c = PH_C - y0_q;
      end
      fbfrh_pkg::ROT_270: begin
        px_lo_c = y0_q;         px_hi_c = y1_q;
        py_lo_c = PH_C - x1_q;  py_hi_c = PH_C - x0_q;
      end
      default: begin
        px_lo_c = x0_q;         px_hi_c = x1_q;
        py_lo_c = y0_q;         py_hi_c = y1_q;
      end
    endcase
  end

  assign out_free  = !m_valid_q || m_axis_tready;
  assign row_end   = (px_q == px_hi_q - CW'(1));
  assign rect_end  = row_end && (py_q == py_hi_q - CW'(1));
  assign wr_addr   = row_base_q + AW'(px_q);
  assign mem_we    = (state_q == ST_FILL);
  assign rd_en     = (state_q == ST_HASH) && !phase_q;
  assign hash_ctrl.clr       = (state_q == ST_CLIP) && (act_q == fbfrh_pkg::ACT_HASH);
  assign hash_ctrl.pix_valid = (state_q == ST_HASH) && phase_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= fbfrh_pkg::ACT_PIXEL;
      rot_q     <= fbfrh_pkg::ROT_0;
      dirty_q   <= 1'b0;
      phase_q   <= 1'b0;
      last_q    <= 1'b0;
      rd_addr_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        rot_q <= cfg_data_i;
      end
      if ((state_q == ST_RESULT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act_q   <= fbfrh_pkg::action_e'(s_axis_tuser);
            state_q <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          phase_q   <= 1'b0;
          last_q    <= 1'b0;
          rd_addr_q <= '0;
          unique case (act_q)
            fbfrh_pkg::ACT_HASH: state_q <= ST_HASH;
            fbfrh_pkg::ACT_MARK: begin
              dirty_q <= 1'b0;
              state_q <= ST_RESULT;
            end
            default: state_q <= empty_c ? ST_RESULT : ST_MAP;
          endcase
        end
        ST_MAP: begin
          dirty_q <= 1'b1;
          state_q <= ST_BASE;
        end
        ST_BASE: begin
          state_q <= ST_FILL;
        end
        ST_FILL: begin
          if (rect_end) begin
            state_q <= ST_RESULT;
          end
        end
        ST_HASH: begin
          phase_q <= !phase_q;
          if (!phase_q) begin
            rd_addr_q <= rd_addr_q + AW'(1);
            last_q    <= (rd_addr_q == LAST_ADDR);
          end else if (last_q) begin
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            m_data_q <= {7'd0, dirty_q,
                         (act_q == fbfrh_pkg::ACT_HASH) ? hash_val : 32'd0};
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      x_q     <= s_axis_tdata[15:0];
      y_q     <= s_axis_tdata[31:16];
      w_q     <= s_axis_tdata[47:32];
      h_q     <= s_axis_tdata[63:48];
      color_q <= s_axis_tdata[79:64];
    end
    if (state_q == ST_CLIP) begin
      x0_q    <= x0_s[CW-1:0];
      x1_q    <= x1_s[CW-1:0];
      y0_q    <= y0_s[CW-1:0];
      y1_q    <= y1_s[CW-1:0];
      empty_q <= empty_c;
    end
    if (state_q == ST_MAP) begin
      px_lo_q <= px_lo_c;
      px_hi_q <= px_hi_c;
      py_lo_q <= py_lo_c;
      py_hi_q <= py_hi_c;
    end
    if (state_q == ST_BASE) begin
      row_base_q <= AW'(int'(py_lo_q) * PANEL_WIDTH);
      px_q       <= px_lo_q;
      py_q       <= py_lo_q;
    end
    if (state_q == ST_FILL) begin
      if (row_end) begin
        px_q       <= px_lo_q;
        py_q       <= py_q + CW'(1);
        row_base_q <= row_base_q + ROW_STEP;
      end else begin
        px_q <= px_q + CW'(1);
      end
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= color_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  fbfrh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hash_ctrl),
    .pix_i  (rd_data_q),
    .hash_o (hash_val)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  a_fill_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> (px_q < px_hi_q) && (py_q < py_hi_q) && !empty_q)
    else $error("fill walked outside rectangle");

  a_write_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> dirty_q) else $error("store written without dirty");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) && out_free |=> m_valid_q && (state_q == ST_IDLE))
    else $error("result not loaded");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_addr_q <= LAST_ADDR) && !last_q) else $error("read past store");

endmodule

/* verif/framebuffer_fill_rotate_hash_core_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the rgb565 frame store core: pixel writes, clipped fills and mark
// presented across all four rotations, plus checksums, with random idling on both streams
// depends on fbfrh_pkg and framebuffer_fill_rotate_hash_core

module framebuffer_fill_rotate_hash_core_tb;

  localparam int PANEL_WIDTH  = 172;
  localparam int PANEL_HEIGHT = 320;
  localparam int STORE_DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int PHASE_WORDS  = 20;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 16;
  localparam int STALL_LIMIT  = 500000;

  typedef struct packed {
    logic [31:0] hash;
    logic        dirty;
  } frame_result_t;

  class frame_store_tracker;
    bit [15:0]     pixels [STORE_DEPTH];
    logic [1:0]    rotation;
    bit            dirty;
    frame_result_t pending_results [$];
    int            mismatches;
    int            results_seen;
    int            action_count [4];

    function int logical_w();
      return rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    endfunction

    function int logical_h();
      return rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    endfunction

    function void store_pixel(int x, int y, logic [15:0] color);
      int px, py;
      case (rotation)
        fbfrh_pkg::ROT_90: begin
          px = PANEL_WIDTH - 1 - y;
          py = x;
        end
        fbfrh_pkg::ROT_180: begin
          px = PANEL_WIDTH - 1 - x;
          py = PANEL_HEIGHT - 1 - y;
        end
        fbfrh_pkg::ROT_270: begin
          px = y;
          py = PANEL_HEIGHT - 1 - x;
        end
        default: begin
          px = x;
          py = y;
        end
      endcase
      pixels[py * PANEL_WIDTH + px] = color;
      dirty = 1'b1;
    endfunction

    // fnv-1a 32, physical order, high byte of each pixel first
    function logic [31:0] frame_hash();
      logic [31:0] h;
      h = fbfrh_pkg::HASH_BASIS;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        h = (h ^ {24'd0, pixels[i][15:8]}) * fbfrh_pkg::HASH_PRIME;
        h = (h ^ {24'd0, pixels[i][7:0]}) * fbfrh_pkg::HASH_PRIME;
      end
      return h;
    endfunction

    function void apply_command(fbfrh_pkg::action_e act, logic [15:0] x_raw,
                                logic [15:0] y_raw, logic [15:0] w_raw,
                                logic [15:0] h_raw, logic [15:0] color);
      int x, y, w, h, x0, y0, x1, y1;
      frame_result_t r;
      x = $signed(x_raw);
      y = $signed(y_raw);
      w = $signed(w_raw);
      h = $signed(h_raw);
      r.hash = '0;
      action_count[act]++;
      case (act)
        fbfrh_pkg::ACT_PIXEL: begin
          if (x >= 0 && y >= 0 && x < logical_w() && y < logical_h())
            store_pixel(x, y, color);
        end
        fbfrh_pkg::ACT_FILL: begin
          if (w > 0 && h > 0) begin
            x0 = (x < 0) ? 0 : x;
            y0 = (y < 0) ? 0 : y;
            x1 = x + w;
            y1 = y + h;
            if (x1 > logical_w()) x1 = logical_w();
            if (y1 > logical_h()) y1 = logical_h();
            for (int j = y0; j < y1; j++)
              for (int i = x0; i < x1; i++)
                store_pixel(i, j, color);
          end
        end
        fbfrh_pkg::ACT_HASH: r.hash = frame_hash();
        default: dirty = 1'b0;
      endcase
      r.dirty = dirty;
      pending_results.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [31:0] hash, logic d);
      frame_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected word: frame_hash %h dirty %b", hash, d));
        return;
      end
      want = pending_results.pop_front();
      if (hash !== want.hash)
        note_mismatch($sformatf("frame_hash expected %h got %h", want.hash, hash));
      if (d !== want.dirty)
        note_mismatch($sformatf("dirty expected %b got %b", want.dirty, d));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // x_pos, y_pos, rect_width, rect_height, color
  logic [1:0]  s_axis_tuser = fbfrh_pkg::ACT_MARK;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // frame_hash, dirty, zero pad
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = fbfrh_pkg::ROT_0;

  frame_store_tracker tracker = new();
  bit no_idle;
  bit hold_request;
  bit hold_done;
  int hash_budget = 2;

  framebuffer_fill_rotate_hash_core #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tdata[31:0], m_axis_tdata[32]);
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // valid stays high between back-to-back words; it only drops for a gap
  task automatic send_word(fbfrh_pkg::action_e act, logic [15:0] x, logic [15:0] y,
                           logic [15:0] w, logic [15:0] h, logic [15:0] color);
    if (!no_idle && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 35);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {color, h, w, y, x};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_command(act, x, y, w, h, color);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_rotation(logic [1:0] rot);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rot;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.rotation = rot;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    send_word(fbfrh_pkg::ACT_PIXEL, 16'($urandom_range(tracker.logical_w() - 1)),
              16'($urandom_range(tracker.logical_h() - 1)), 16'($urandom()),
              16'($urandom()), 16'($urandom()));
  endtask

  task automatic send_random_word();
    int pick;
    fbfrh_pkg::action_e act;
    logic [15:0] x, y, w, h, color;
    pick  = $urandom_range(99);
    color = 16'($urandom());
    x = 16'(int'($urandom_range(tracker.logical_w() + 3)) - 2);
    y = 16'(int'($urandom_range(tracker.logical_h() + 3)) - 2);
    w = 16'(int'($urandom_range(18)) - 2);
    h = 16'(int'($urandom_range(18)) - 2);
    if (pick < 45) begin
      act = fbfrh_pkg::ACT_PIXEL;
    end else if (pick < 80) begin
      act = fbfrh_pkg::ACT_FILL;
    end else if (pick < 88 || (pick < 92 && hash_budget == 0)) begin
      act = fbfrh_pkg::ACT_MARK;
    end else if (pick < 92) begin
      act = fbfrh_pkg::ACT_HASH;
      hash_budget--;
    end else begin
      // noise: full-range fields
      act = pick[0] ? fbfrh_pkg::ACT_FILL : fbfrh_pkg::ACT_PIXEL;
      x = 16'($urandom());
      y = 16'($urandom());
      w = 16'($urandom());
      h = 16'($urandom());
    end
    send_word(act, x, y, w, h, color);
  endtask

  task automatic run_phase(logic [1:0] rot);
    wait_drain();
    write_rotation(rot);
    repeat (PHASE_WORDS) send_random_word();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    write_rotation(fbfrh_pkg::ROT_0);

    // whole screen first so that every pixel is defined before a checksum
    send_word(fbfrh_pkg::ACT_FILL, 16'd0, 16'd0, 16'd172, 16'd320, 16'hffff);
    send_word(fbfrh_pkg::ACT_HASH, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(fbfrh_pkg::ACT_MARK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(fbfrh_pkg::ACT_MARK, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // pixels just outside the left, right and bottom edges and one far outside, dirty must stay clear
    send_word(fbfrh_pkg::ACT_PIXEL, 16'hffff, 16'd0, 16'd0, 16'd0, 16'h1111);
    send_word(fbfrh_pkg::ACT_PIXEL, 16'd172, 16'd0, 16'd0, 16'd0, 16'h2222);
    send_word(fbfrh_pkg::ACT_PIXEL, 16'd0, 16'd320, 16'd0, 16'd0, 16'h3333);
    send_word(fbfrh_pkg::ACT_PIXEL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000);
    // empty and fully clipped fills
    send_word(fbfrh_pkg::ACT_FILL, 16'd4, 16'd4, 16'd0, 16'd5, 16'h4444);
    send_word(fbfrh_pkg::ACT_FILL, 16'd4, 16'd4, 16'h8000, 16'h7fff, 16'h5555);
    send_word(fbfrh_pkg::ACT_FILL, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h6666);
    send_word(fbfrh_pkg::ACT_FILL, 16'h7fff, 16'd0, 16'h7fff, 16'd1, 16'h7777);
    send_word(fbfrh_pkg::ACT_FILL, 16'hfffb, 16'd310, 16'd3, 16'd4, 16'h8888);
    // corners and partly clipped fills
    send_word(fbfrh_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
    send_word(fbfrh_pkg::ACT_PIXEL, 16'd171, 16'd319, 16'd0, 16'd0, 16'h8001);
    send_word(fbfrh_pkg::ACT_FILL, 16'hfffd, 16'hfffe, 16'd6, 16'd5, 16'h1234);
    send_word(fbfrh_pkg::ACT_FILL, 16'd168, 16'd316, 16'h7fff, 16'h7fff, 16'h7ffe);
    send_word(fbfrh_pkg::ACT_HASH, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(fbfrh_pkg::ACT_MARK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

    // output held off while the sender keeps pushing
    wait_drain();
    write_rotation(fbfrh_pkg::ROT_90);
    hold_request = 1'b1;
    while (!hold_done) send_random_pixel();
    repeat (PHASE_WORDS) send_random_word();

    no_idle = 1'b1;
    run_phase(fbfrh_pkg::ROT_180);
    wait_drain();
    no_idle = 1'b0;

    run_phase(fbfrh_pkg::ROT_270);
    send_word(fbfrh_pkg::ACT_HASH, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(fbfrh_pkg::ROT_0);

    wait_drain();
    $display("covered %0d pixel writes, %0d fills, %0d checksums, %0d marks in four rotations",
             tracker.action_count[fbfrh_pkg::ACT_PIXEL],
             tracker.action_count[fbfrh_pkg::ACT_FILL],
             tracker.action_count[fbfrh_pkg::ACT_HASH],
             tracker.action_count[fbfrh_pkg::ACT_MARK]);
    $display("%0d result words checked, %0d mismatches, %0d still expected",
             tracker.results_seen, tracker.mismatches, tracker.pending_results.size());
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
